// ===== hw/rtl/bgr_pixels_to_led_bitplanes_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the pixel to LED bit-plane converter checks.
// ----------------------------------------------------------------------------
`ifndef BGR_PIXELS_TO_LED_BITPLANES_MACROS_SVH
`define BGR_PIXELS_TO_LED_BITPLANES_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BGRLB_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define BGRLB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/bgrlb_pkg.sv =====
// ----------------------------------------------------------------------------
// bgrlb_pkg
// Types and constants shared by the pixel to LED bit-plane converter.
// ----------------------------------------------------------------------------
package bgrlb_pkg;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic FMT_24 = 1'b0;
   localparam logic FMT_32 = 1'b1;

   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;
   localparam logic [1:0] PHASE_ALPHA = 2'd3;

   localparam logic [1:0] PLANE_RED   = 2'd0;
   localparam logic [1:0] PLANE_GREEN = 2'd1;
   localparam logic [1:0] PLANE_BLUE  = 2'd2;

   localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
   localparam logic [2:0] REG_BOTTOM_UP    = 3'd3;
   localparam logic [2:0] REG_THRESHOLD    = 3'd4;

   localparam logic        RST_PIXEL_FORMAT = 1'b0;
   localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd96;
   localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd24;
   localparam logic        RST_BOTTOM_UP    = 1'b1;
   localparam logic [7:0]  RST_THRESHOLD    = 8'd127;

   localparam logic [12:0] ROW_COUNT_MAX = 13'h1FFF;

   localparam logic [13:0] DIV3_MUL   = 14'd43;
   localparam int          DIV3_SHIFT = 7;

   localparam int PLANES = 3;
   localparam int WORD_W = PLANES * 8;

   typedef struct packed {
      logic        pixel_format;
      logic [11:0] image_width;
      logic [11:0] image_height;
      logic        bottom_up;
      logic [7:0]  threshold;
   } cfg_type;

   typedef struct packed {
      logic       is_read;
      logic       store;
      logic [2:0] color;
      logic [2:0] bit_sel;
      logic [1:0] plane;
      logic       rd_ok;
      logic       written;
      logic       clipped;
   } cmd_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       pixel_written;
      logic       pixel_clipped;
   } rsp_type;

endpackage

// ===== hw/rtl/bgrlb_if.sv =====
// ----------------------------------------------------------------------------
// bgrlb_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface bgrlb_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic       frame_start;
   logic [6:0] read_row;
   logic [3:0] read_col;

   modport source (output valid, operation, data_byte, frame_start, read_row, read_col,
                   input ready);
   modport sink (input valid, operation, data_byte, frame_start, read_row, read_col,
                 output ready);
endinterface

interface bgrlb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       pixel_written;
   logic       pixel_clipped;

   modport source (output valid, read_data, pixel_written, pixel_clipped, input ready);
   modport sink (input valid, read_data, pixel_written, pixel_clipped, output ready);
endinterface

// ===== hw/rtl/bgrlb_ram.sv =====
// ----------------------------------------------------------------------------
// bgrlb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bgrlb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 288,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bgrlb_front.sv =====
// ----------------------------------------------------------------------------
// bgrlb_front
// Byte decode: tracks pixel position and forms the framebuffer command.
// ----------------------------------------------------------------------------
module bgrlb_front #(
   parameter int PANEL_BYTES_PER_ROW = 12,
   parameter int PANEL_LINES = 24,
   parameter int AW = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 operation,
   input  logic [7:0]           data_byte,
   input  logic                 frame_start,
   input  logic [6:0]           read_row,
   input  logic [3:0]           read_col,
   input  bgrlb_pkg::cfg_type   cfg,
   output bgrlb_pkg::cmd_type   cmd,
   output logic [AW-1:0]        addr
);

   localparam int PANEL_ROWS = PANEL_LINES * 3;
   localparam int PANEL_COLS = PANEL_BYTES_PER_ROW * 8;

   logic [11:0] col_ff, col_in, col_cur, col_inc;
   logic [12:0] row_ff, row_in, row_cur, row_inc, line;
   logic [1:0]  phase_ff, phase_in, phase_cur;
   logic [1:0]  partial_ff, partial_in, partial_cur;
   logic [1:0]  pad_ff, pad_in, pad_cur, three_w, pad_calc;
   logic        bit_on, in_image, on_panel, row_end;
   logic [6:0]  quot, quot3, rem_full;
   logic [13:0] quot_prod;
   logic [AW-1:0] pix_addr, rd_addr;

   always_comb begin
      col_cur     = frame_start ? 12'd0 : col_ff;
      row_cur     = frame_start ? 13'd0 : row_ff;
      phase_cur   = frame_start ? bgrlb_pkg::PHASE_BLUE : phase_ff;
      partial_cur = frame_start ? 2'd0 : partial_ff;
      pad_cur     = frame_start ? 2'd0 : pad_ff;
      bit_on      = data_byte >= cfg.threshold;

      in_image = row_cur < {1'b0, cfg.image_height};
      line     = cfg.bottom_up ? ({1'b0, cfg.image_height} - 13'd1 - row_cur) : row_cur;
      on_panel = in_image && (line < 13'(PANEL_LINES)) && (col_cur < 12'(PANEL_COLS));
      col_inc  = col_cur + 12'd1;
      row_end  = col_inc >= cfg.image_width;
      row_inc  = (row_cur == bgrlb_pkg::ROW_COUNT_MAX) ? row_cur : row_cur + 13'd1;
      three_w  = cfg.image_width[1:0] + {cfg.image_width[0], 1'b0};
      pad_calc = 2'd0 - three_w;
      pix_addr = AW'(32'(line) * PANEL_BYTES_PER_ROW + 32'(col_cur[11:3]));

      quot_prod = 14'(read_row) * bgrlb_pkg::DIV3_MUL;
      quot      = 7'(quot_prod >> bgrlb_pkg::DIV3_SHIFT);
      quot3     = {quot[5:0], 1'b0} + quot;
      rem_full  = read_row - quot3;
      rd_addr   = AW'(32'(quot) * PANEL_BYTES_PER_ROW + 32'(read_col));

      col_in     = col_ff;
      row_in     = row_ff;
      phase_in   = phase_ff;
      partial_in = partial_ff;
      pad_in     = pad_ff;
      cmd        = '0;
      addr       = (operation == bgrlb_pkg::OP_READ) ? rd_addr : pix_addr;

      cmd.bit_sel = col_cur[2:0];
      cmd.plane   = rem_full[1:0];
      cmd.rd_ok   = (10'(read_row) < 10'(PANEL_ROWS)) &&
                    (7'(read_col) < 7'(PANEL_BYTES_PER_ROW));

      if (operation == bgrlb_pkg::OP_READ) begin
         cmd.is_read = 1'b1;
      end else if (accept) begin
         col_in     = col_cur;
         row_in     = row_cur;
         phase_in   = phase_cur;
         partial_in = partial_cur;
         pad_in     = pad_cur;
         if (pad_cur != 2'd0) begin
            pad_in = pad_cur - 2'd1;
         end else begin
            case (phase_cur)
               bgrlb_pkg::PHASE_BLUE: begin
                  partial_in = {bit_on, 1'b0};
                  phase_in   = bgrlb_pkg::PHASE_GREEN;
               end
               bgrlb_pkg::PHASE_GREEN: begin
                  partial_in = {partial_cur[1], bit_on};
                  phase_in   = bgrlb_pkg::PHASE_RED;
               end
               bgrlb_pkg::PHASE_RED: begin
                  partial_in  = 2'd0;
                  phase_in    = (cfg.pixel_format == bgrlb_pkg::FMT_32) ?
                                bgrlb_pkg::PHASE_ALPHA : bgrlb_pkg::PHASE_BLUE;
                  cmd.color   = {partial_cur, bit_on};
                  cmd.store   = on_panel;
                  cmd.written = on_panel;
                  cmd.clipped = !on_panel;
                  col_in      = col_inc;
                  if (row_end) begin
                     col_in = 12'd0;
                     row_in = row_inc;
                     if (cfg.pixel_format == bgrlb_pkg::FMT_24) begin
                        pad_in = pad_calc;
                     end
                  end
               end
               default: begin
                  phase_in = bgrlb_pkg::PHASE_BLUE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         phase_ff   <= bgrlb_pkg::PHASE_BLUE;
         partial_ff <= '0;
         pad_ff     <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
         pad_ff     <= pad_in;
      end
   end

endmodule

// ===== hw/rtl/bgrlb_rmw.sv =====
// ----------------------------------------------------------------------------
// bgrlb_rmw
// Framebuffer read-modify-write stage with forwarding and the reset clear.
// ----------------------------------------------------------------------------
module bgrlb_rmw #(
   parameter int DEPTH = 288,
   parameter int AW = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  bgrlb_pkg::cmd_type            cmd,
   input  logic [AW-1:0]                 addr,
   input  logic [bgrlb_pkg::WORD_W-1:0]  ram_rdata,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [bgrlb_pkg::WORD_W-1:0]  ram_wdata,
   output logic                          clearing,
   output logic                          res_valid,
   output bgrlb_pkg::rsp_type            res
);

   logic                         s1_valid_ff;
   bgrlb_pkg::cmd_type           s1_cmd_ff;
   logic [AW-1:0]                s1_addr_ff;
   logic                         fwd_ff, fwd_in;
   logic [bgrlb_pkg::WORD_W-1:0] fwd_data_ff;
   logic                         clr_busy_ff;
   logic [AW-1:0]                clr_addr_ff;
   logic [bgrlb_pkg::WORD_W-1:0] cur_word, new_word;
   logic                         upd_we;
   logic [7:0]                   sel_byte;

   always_comb begin
      cur_word = fwd_ff ? fwd_data_ff : ram_rdata;
      new_word = cur_word;
      for (int p = 0; p < bgrlb_pkg::PLANES; p++) begin
         new_word[8 * p + int'(s1_cmd_ff.bit_sel)] = s1_cmd_ff.color[p];
      end
      case (s1_cmd_ff.plane)
         bgrlb_pkg::PLANE_RED:   sel_byte = cur_word[7:0];
         bgrlb_pkg::PLANE_GREEN: sel_byte = cur_word[15:8];
         default:                sel_byte = cur_word[23:16];
      endcase
   end

   assign upd_we    = s1_valid_ff && s1_cmd_ff.store;
   assign ram_we    = clr_busy_ff || upd_we;
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wdata = clr_busy_ff ? '0 : new_word;
   assign fwd_in    = accept && upd_we && (addr == s1_addr_ff);
   assign clearing  = clr_busy_ff;

   assign res_valid         = s1_valid_ff;
   assign res.read_data     = (s1_cmd_ff.is_read && s1_cmd_ff.rd_ok) ? sel_byte : 8'd0;
   assign res.pixel_written = s1_cmd_ff.written;
   assign res.pixel_clipped = s1_cmd_ff.clipped;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         s1_valid_ff <= accept;
         fwd_ff      <= fwd_in;
         if (clr_busy_ff) begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= cmd;
      s1_addr_ff  <= addr;
      fwd_data_ff <= new_word;
   end

endmodule

// ===== hw/rtl/bgrlb_outq.sv =====
// ----------------------------------------------------------------------------
// bgrlb_outq
// Two-entry response queue that decouples the pipeline from the sink.
// ----------------------------------------------------------------------------
module bgrlb_outq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bgrlb_pkg::rsp_type push_data,
   output logic [1:0]         level,
   output logic               pop,
   bgrlb_rsp_if.source        rsp_bus
);

   bgrlb_pkg::rsp_type entry_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         level_ff;
   bgrlb_pkg::rsp_type head;

   assign head                  = entry_ff[rd_ptr_ff];
   assign rsp_bus.valid         = level_ff != 2'd0;
   assign rsp_bus.read_data     = head.read_data;
   assign rsp_bus.pixel_written = head.pixel_written;
   assign rsp_bus.pixel_clipped = head.pixel_clipped;
   assign pop                   = rsp_bus.valid && rsp_bus.ready;
   assign level                 = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         level_ff <= level_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/bgr_pixels_to_led_bitplanes.sv =====
// Responses: an accepted item is registered in the RMW stage, then in the output queue.
// Throughput: one item per cycle while req_bus.ready is high; the framebuffer RAM has one
// read and one write port and the write-back of a pixel is forwarded to a following access
// of the same word. Reset: synchronous; afterwards the RAM is cleared one word per cycle
// over all PANEL_LINES * PANEL_BYTES_PER_ROW words (288 by default), req_bus.ready low.
// ----------------------------------------------------------------------------
// bgr_pixels_to_led_bitplanes
// Converts BGR pixel bytes to thresholded red, green and blue LED bit-planes.
// ----------------------------------------------------------------------------
module bgr_pixels_to_led_bitplanes #(
   parameter int PANEL_BYTES_PER_ROW = 12,
   parameter int PANEL_LINES = 24
) (
   input  logic        clock,
   input  logic        reset,
   bgrlb_req_if.sink   req_bus,
   bgrlb_rsp_if.source rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int DEPTH = PANEL_LINES * PANEL_BYTES_PER_ROW;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   bgrlb_pkg::cfg_type           cfg_ff;
   bgrlb_pkg::cmd_type           cmd;
   bgrlb_pkg::rsp_type           res;
   logic [AW-1:0]                addr, ram_waddr;
   logic [bgrlb_pkg::WORD_W-1:0] ram_rdata, ram_wdata;
   logic                         ram_we, clearing, res_valid, accept, pop, cfg_wr;
   logic [1:0]                   level, occupied;

   assign pready   = 1'b1;
   assign cfg_wr   = psel && penable && pwrite && pready;
   assign occupied = level + {1'b0, res_valid};
   assign req_bus.ready = !clearing && ((occupied < 2'd2) || (occupied == 2'd2 && pop));
   assign accept   = req_bus.valid && req_bus.ready;

   always_comb begin
      case (paddr[4:2])
         bgrlb_pkg::REG_PIXEL_FORMAT: prdata = 32'(cfg_ff.pixel_format);
         bgrlb_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_ff.image_width);
         bgrlb_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_ff.image_height);
         bgrlb_pkg::REG_BOTTOM_UP:    prdata = 32'(cfg_ff.bottom_up);
         bgrlb_pkg::REG_THRESHOLD:    prdata = 32'(cfg_ff.threshold);
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= bgrlb_pkg::RST_PIXEL_FORMAT;
         cfg_ff.image_width  <= bgrlb_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height <= bgrlb_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.bottom_up    <= bgrlb_pkg::RST_BOTTOM_UP;
         cfg_ff.threshold    <= bgrlb_pkg::RST_THRESHOLD;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            bgrlb_pkg::REG_PIXEL_FORMAT: cfg_ff.pixel_format <= pwdata[0];
            bgrlb_pkg::REG_IMAGE_WIDTH:  cfg_ff.image_width  <= pwdata[11:0];
            bgrlb_pkg::REG_IMAGE_HEIGHT: cfg_ff.image_height <= pwdata[11:0];
            bgrlb_pkg::REG_BOTTOM_UP:    cfg_ff.bottom_up    <= pwdata[0];
            bgrlb_pkg::REG_THRESHOLD:    cfg_ff.threshold    <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   bgrlb_front #(
      .PANEL_BYTES_PER_ROW(PANEL_BYTES_PER_ROW),
      .PANEL_LINES(PANEL_LINES),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .operation(req_bus.operation),
      .data_byte(req_bus.data_byte),
      .frame_start(req_bus.frame_start),
      .read_row(req_bus.read_row),
      .read_col(req_bus.read_col),
      .cfg(cfg_ff),
      .cmd(cmd),
      .addr(addr)
   );

   bgrlb_ram #(
      .WIDTH(bgrlb_pkg::WORD_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(addr),
      .rd_data(ram_rdata)
   );

   bgrlb_rmw #(
      .DEPTH(DEPTH),
      .AW(AW)
   ) u_rmw (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .cmd(cmd),
      .addr(addr),
      .ram_rdata(ram_rdata),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .clearing(clearing),
      .res_valid(res_valid),
      .res(res)
   );

   bgrlb_outq u_outq (
      .clock(clock),
      .reset(reset),
      .push(res_valid),
      .push_data(res),
      .level(level),
      .pop(pop),
      .rsp_bus(rsp_bus)
   );

endmodule

// ===== hw/rtl/bgrlb_checker.sv =====
// ----------------------------------------------------------------------------
// bgrlb_checker
// Port-level checks for the pixel to LED bit-plane converter.
// ----------------------------------------------------------------------------
`include "bgr_pixels_to_led_bitplanes_macros.svh"

module bgrlb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] read_data,
   input logic       pixel_written,
   input logic       pixel_clipped
);

   `BGRLB_ASSERT_IMP(a_flags_exclusive, clock, reset, rsp_valid,
                     !(pixel_written && pixel_clipped))
   `BGRLB_ASSERT_IMP(a_data_only_on_read, clock, reset, rsp_valid && read_data != 8'd0,
                     !pixel_written && !pixel_clipped)
   `BGRLB_ASSERT_IMP(a_clear_blocks_input, clock, reset, $fell(reset), !req_ready)
   `BGRLB_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind bgr_pixels_to_led_bitplanes bgrlb_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .read_data(rsp_bus.read_data),
   .pixel_written(rsp_bus.pixel_written),
   .pixel_clipped(rsp_bus.pixel_clipped)
);
